// ===== design/mbm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared constants, register codes and types of the binary mask morphology
// block.
// ----------------------------------------------------------------------------
package mbm_pkg;

   localparam int MAX_KERNEL_DEF = 7;
   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS_DEF   = 1024;
   localparam int PIXEL_BITS_DEF = 16;

   // widths of the software visible registers
   localparam int FILL_REG_W = 16;
   localparam int KDIM_REG_W = 3;
   localparam int IDIM_REG_W = 11;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE        = 3'd0,
      REG_FILL_VALUE  = 3'd1,
      REG_KERNEL_ROWS = 3'd2,
      REG_KERNEL_COLS = 3'd3,
      REG_KERNEL_MASK = 3'd4,
      REG_IMAGE_ROWS  = 3'd5,
      REG_IMAGE_COLS  = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_DILATE = 1'b0,
      MODE_ERODE  = 1'b1
   } mode_type;

   // configuration data bus is as wide as the widest register
   function automatic int csr_width(input int mk);
      return (mk * mk > FILL_REG_W) ? mk * mk : FILL_REG_W;
   endfunction

endpackage

// ===== design/mbm_stream_if.sv =====
// ----------------------------------------------------------------------------
// mbm_stream_if
// Valid/ready channels of the morphology block: pixel requests and results.
// ----------------------------------------------------------------------------
interface mbm_req_if import mbm_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] in_pixel;
   logic                  filler;

   modport source (output valid, in_pixel, filler, input ready);
   modport sink   (input valid, in_pixel, filler, output ready);
endinterface

interface mbm_rsp_if import mbm_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_pixel;
   logic                  frame_last;

   modport source (output valid, out_pixel, frame_last, input ready);
   modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

// ===== design/mbm_line_buf.sv =====
// ----------------------------------------------------------------------------
// mbm_line_buf
// Cascade of line memories; line k holds the pixels of k+1 rows above the
// incoming column. Registered read with write-through on a same-address hit.
// ----------------------------------------------------------------------------
module mbm_line_buf import mbm_pkg::*; #(
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   parameter int LINES      = MAX_KERNEL_DEF - 1
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_COLS)-1:0]         rd_addr,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_COLS)-1:0]         wr_addr,
   input  logic [LINES-1:0][PIXEL_BITS-1:0]    wr_data,
   output logic [LINES-1:0][PIXEL_BITS-1:0]    rd_data
);

   logic hit;

   assign hit = wr_en && (wr_addr == rd_addr);

   for (genvar k = 0; k < LINES; k++) begin : g_line
      logic [PIXEL_BITS-1:0] mem [MAX_COLS];
      logic [PIXEL_BITS-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data[k];
         end
         if (rd_en) begin
            // single column frames read back the word written at this edge
            rd_ff <= hit ? wr_data[k] : mem[rd_addr];
         end
      end

      assign rd_data[k] = rd_ff;
   end

endmodule

// ===== design/mbm_window.sv =====
// ----------------------------------------------------------------------------
// mbm_window
// Sliding window of pixel registers and the per-tap dilate / erode decision.
// Row a of the window is a rows above the newest pixel, column b is b pixels
// back in the stream.
// ----------------------------------------------------------------------------
module mbm_window import mbm_pkg::*; #(
   parameter int MAX_KERNEL = MAX_KERNEL_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       advance,
   input  logic [MAX_KERNEL-1:0][PIXEL_BITS-1:0]      column,
   input  logic [MAX_KERNEL-1:0]                      row_ok,
   input  logic [MAX_KERNEL-1:0]                      col_ok,
   input  mode_type                                   mode,
   input  logic [PIXEL_BITS-1:0]                      fill_value,
   input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0]      tap_map,
   input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] ctr_row,
   input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] ctr_col,
   output logic [PIXEL_BITS-1:0]                      result
);

   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIXEL_BITS-1:0] win_ff;
   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIXEL_BITS-1:0] win_in;
   logic                                                  hit;

   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
         win_in[a][0] = column[a];
         for (int b = 1; b < MAX_KERNEL; b++) begin
            win_in[a][b] = win_ff[a][b-1];
         end
      end
   end

   always_comb begin
      logic inb;
      logic nz;
      hit = 1'b0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            inb = row_ok[a] && col_ok[b];
            nz  = |win_in[a][b];
            if (mode == MODE_ERODE) begin
               // taps over the frame edge count as background
               if (tap_map[a][b] && (!inb || !nz)) hit = 1'b1;
            end else begin
               if (tap_map[a][b] && inb && nz) hit = 1'b1;
            end
         end
      end
   end

   assign result = hit ? fill_value : win_in[ctr_row][ctr_col];

   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== design/binary_mask_morphology.sv =====
// ----------------------------------------------------------------------------
// binary_mask_morphology
// Binary dilation / erosion of a raster pixel stream with a masked
// structuring element of up to MAX_KERNEL x MAX_KERNEL taps.
// ----------------------------------------------------------------------------
// Pixels enter on req_ch in raster order, one item per cycle unless stalled.
// Results leave on rsp_ch in raster order, frame_last set on the last one.
// A result is due once the pixel at the bottom-right of its window has
// arrived, so results lag the stream by (kr-1-kr/2)*cols + (kc-1-kc/2)
// items; the host sends that many filler items after each frame to drain.
// Fillers inside a frame are taken and dropped.
// On the accept of the completing item the line memory read and the input
// stage load; the window then feeds the result register, which drives
// rsp_ch.valid. Throughput is one item per clock while rsp_ch does not
// stall; the line memory cascade (one read and one write port per line)
// sets that figure.
// Registers are sampled on the first pixel of each frame; write them only
// while the block is idle.
// When rsp_ch stalls the result register holds, the pipeline stage behind
// it fills, and then req_ch.ready drops.
// Synchronous reset clears the counters and the handshake state; the line
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module binary_mask_morphology import mbm_pkg::*; #(
   parameter int MAX_KERNEL = MAX_KERNEL_DEF,
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   mbm_req_if.sink                            req_ch,
   mbm_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [CSR_IDX_W-1:0]               csr_index,
   input  logic [csr_width(MAX_KERNEL)-1:0]   csr_wr_data
);

   localparam int KD_W   = $clog2(MAX_KERNEL + 1);
   localparam int KI_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;
   localparam int RD_W   = $clog2(MAX_ROWS + 1);
   localparam int CD_W   = $clog2(MAX_COLS + 1);
   localparam int ROWC_W = $clog2(MAX_ROWS + MAX_KERNEL + 1);
   localparam int CIDX_W = $clog2(MAX_COLS);
   localparam int CNT_W  = $clog2((MAX_ROWS + MAX_KERNEL) * MAX_COLS + 1);
   localparam int LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int TR_W   = RD_W + KD_W + 1;
   localparam int TC_W   = CD_W + KD_W + 1;

   // software registers
   mode_type                csr_mode_ff;
   logic [FILL_REG_W-1:0]   csr_fill_ff;
   logic [KDIM_REG_W-1:0]   csr_krows_ff;
   logic [KDIM_REG_W-1:0]   csr_kcols_ff;
   logic [TAPS-1:0]         csr_mask_ff;
   logic [IDIM_REG_W-1:0]   csr_irows_ff;
   logic [IDIM_REG_W-1:0]   csr_icols_ff;

   // frame settings derived from the registers
   logic [KD_W-1:0]                          new_kr;
   logic [KD_W-1:0]                          new_kc;
   logic [KI_W-1:0]                          new_dr;
   logic [KI_W-1:0]                          new_dc;
   logic [RD_W-1:0]                          new_rows;
   logic [CD_W-1:0]                          new_cols;
   logic [CNT_W-1:0]                         new_lag;
   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0]    new_map;

   // settings held for the frame in progress
   mode_type                                 lat_mode_ff;
   logic [PIXEL_BITS-1:0]                    lat_fill_ff;
   logic [KI_W-1:0]                          lat_dr_ff;
   logic [KI_W-1:0]                          lat_dc_ff;
   logic [RD_W-1:0]                          lat_rows_ff;
   logic [CD_W-1:0]                          lat_cols_ff;
   logic [CNT_W-1:0]                         lat_lag_ff;
   logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0]    lat_map_ff;

   logic [KI_W-1:0]                          cur_dr;
   logic [KI_W-1:0]                          cur_dc;
   logic [RD_W-1:0]                          cur_rows;
   logic [CD_W-1:0]                          cur_cols;
   logic [CNT_W-1:0]                         cur_lag;

   // stream position counters
   logic [CNT_W-1:0]   in_cnt_ff, in_cnt_in;
   logic [ROWC_W-1:0]  in_row_ff, in_row_in;
   logic [CD_W-1:0]    in_col_ff, in_col_in;
   logic [RD_W-1:0]    out_row_ff, out_row_in;
   logic [CD_W-1:0]    out_col_ff, out_col_in;

   logic               first;
   logic               in_frame;
   logic               active;
   logic               fire;
   logic               last_pix;
   logic               acc;
   logic               take;
   logic [CD_W-1:0]    in_col_plus;
   logic [CD_W-1:0]    out_col_plus;
   logic [MAX_KERNEL-1:0] row_ok;
   logic [MAX_KERNEL-1:0] col_ok;

   // stage between the memory read and the window
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [CIDX_W-1:0]     s1_addr_ff;
   logic                  s1_fire_ff;
   logic                  s1_last_ff;
   logic [MAX_KERNEL-1:0] s1_row_ok_ff;
   logic [MAX_KERNEL-1:0] s1_col_ok_ff;
   logic                  s1_adv;
   logic                  out_free;
   logic                  req_ready;

   logic [LINES-1:0][PIXEL_BITS-1:0]      lb_rd;
   logic [LINES-1:0][PIXEL_BITS-1:0]      lb_wr;
   logic [MAX_KERNEL-1:0][PIXEL_BITS-1:0] column;
   logic [PIXEL_BITS-1:0]                 win_result;

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                  rsp_last_ff;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff  <= MODE_DILATE;
         csr_fill_ff  <= FILL_REG_W'(1);
         csr_krows_ff <= KDIM_REG_W'(3);
         csr_kcols_ff <= KDIM_REG_W'(3);
         csr_mask_ff  <= '0;
         csr_irows_ff <= IDIM_REG_W'(1024);
         csr_icols_ff <= IDIM_REG_W'(1024);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_MODE:        csr_mode_ff  <= mode_type'(csr_wr_data[0]);
            REG_FILL_VALUE:  csr_fill_ff  <= csr_wr_data[FILL_REG_W-1:0];
            REG_KERNEL_ROWS: csr_krows_ff <= csr_wr_data[KDIM_REG_W-1:0];
            REG_KERNEL_COLS: csr_kcols_ff <= csr_wr_data[KDIM_REG_W-1:0];
            REG_KERNEL_MASK: csr_mask_ff  <= csr_wr_data[TAPS-1:0];
            REG_IMAGE_ROWS:  csr_irows_ff <= csr_wr_data[IDIM_REG_W-1:0];
            REG_IMAGE_COLS:  csr_icols_ff <= csr_wr_data[IDIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversized values saturate
   always_comb begin
      if (csr_krows_ff == '0) new_kr = KD_W'(1);
      else if (int'(csr_krows_ff) > MAX_KERNEL) new_kr = KD_W'(MAX_KERNEL);
      else new_kr = KD_W'(csr_krows_ff);
      if (csr_kcols_ff == '0) new_kc = KD_W'(1);
      else if (int'(csr_kcols_ff) > MAX_KERNEL) new_kc = KD_W'(MAX_KERNEL);
      else new_kc = KD_W'(csr_kcols_ff);
      if (csr_irows_ff == '0) new_rows = RD_W'(1);
      else if (int'(csr_irows_ff) > MAX_ROWS) new_rows = RD_W'(MAX_ROWS);
      else new_rows = RD_W'(csr_irows_ff);
      if (csr_icols_ff == '0) new_cols = CD_W'(1);
      else if (int'(csr_icols_ff) > MAX_COLS) new_cols = CD_W'(MAX_COLS);
      else new_cols = CD_W'(csr_icols_ff);
   end

   // window rows / cols below and right of the centre
   assign new_dr  = KI_W'(new_kr - KD_W'(1) - (new_kr >> 1));
   assign new_dc  = KI_W'(new_kc - KD_W'(1) - (new_kc >> 1));
   assign new_lag = CNT_W'(new_dr) * CNT_W'(new_cols) + CNT_W'(new_dc);

   // tap (i,j) of the mask lands at window row kr-1-i, column kc-1-j
   always_comb begin
      logic [KI_W-1:0] ri;
      logic [KI_W-1:0] ci;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         for (int b = 0; b < MAX_KERNEL; b++) begin
            ri = KI_W'(new_kr - KD_W'(1) - KD_W'(a));
            ci = KI_W'(new_kc - KD_W'(1) - KD_W'(b));
            if ((KD_W'(a) < new_kr) && (KD_W'(b) < new_kc)) begin
               new_map[a][b] = csr_mask_ff[int'(ri) * MAX_KERNEL + int'(ci)];
            end else begin
               new_map[a][b] = 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------ counters
   assign first    = (in_cnt_ff == '0);
   assign cur_dr   = first ? new_dr   : lat_dr_ff;
   assign cur_dc   = first ? new_dc   : lat_dc_ff;
   assign cur_rows = first ? new_rows : lat_rows_ff;
   assign cur_cols = first ? new_cols : lat_cols_ff;
   assign cur_lag  = first ? new_lag  : lat_lag_ff;

   assign in_frame = in_row_ff < ROWC_W'(cur_rows);
   assign active   = !(req_ch.filler && in_frame);
   assign fire     = in_cnt_ff >= cur_lag;
   assign last_pix = (out_row_ff == RD_W'(cur_rows - RD_W'(1)))
                  && (out_col_ff == CD_W'(cur_cols - CD_W'(1)));

   assign acc  = req_ch.valid && req_ready;
   assign take = acc && active;

   assign in_col_plus  = in_col_ff + CD_W'(1);
   assign out_col_plus = out_col_ff + CD_W'(1);

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (take) begin
         in_cnt_in = in_cnt_ff + CNT_W'(1);
         if (in_col_plus >= cur_cols) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROWC_W'(1);
         end else begin
            in_col_in = in_col_plus;
         end
         if (fire) begin
            if (last_pix) begin
               // frame complete, next item opens a new frame
               in_cnt_in  = '0;
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
            end else if (out_col_plus >= cur_cols) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RD_W'(1);
            end else begin
               out_col_in = out_col_plus;
            end
         end
      end
   end

   // frame bounds of each window row and column for the result being issued
   always_comb begin
      logic [TR_W-1:0] tr;
      logic [TC_W-1:0] tc;
      tr = TR_W'(out_row_ff) + TR_W'(cur_dr);
      tc = TC_W'(out_col_ff) + TC_W'(cur_dc);
      for (int a = 0; a < MAX_KERNEL; a++) begin
         row_ok[a] = (tr >= TR_W'(a)) && ((tr - TR_W'(a)) < TR_W'(cur_rows));
         col_ok[a] = (tc >= TC_W'(a)) && ((tc - TC_W'(a)) < TC_W'(cur_cols));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && first) begin
         lat_mode_ff <= csr_mode_ff;
         lat_fill_ff <= PIXEL_BITS'(csr_fill_ff);
         lat_dr_ff   <= new_dr;
         lat_dc_ff   <= new_dc;
         lat_rows_ff <= new_rows;
         lat_cols_ff <= new_cols;
         lat_lag_ff  <= new_lag;
         lat_map_ff  <= new_map;
      end
   end

   // ------------------------------------------------------------ pipeline
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv    = s1_valid_ff && (!s1_fire_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pixel_ff  <= req_ch.in_pixel;
         s1_addr_ff   <= in_col_ff[CIDX_W-1:0];
         s1_fire_ff   <= fire;
         s1_last_ff   <= last_pix;
         s1_row_ok_ff <= row_ok;
         s1_col_ok_ff <= col_ok;
      end
   end

   for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_column
      if (a == 0) begin : g_new
         assign column[a] = s1_pixel_ff;
      end else begin : g_old
         assign column[a] = lb_rd[a-1];
      end
   end

   for (genvar k = 0; k < LINES; k++) begin : g_wr
      assign lb_wr[k] = column[k];
   end

   mbm_line_buf #(
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS),
      .LINES      (LINES)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (take),
      .rd_addr (in_col_ff[CIDX_W-1:0]),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   mbm_window #(
      .MAX_KERNEL (MAX_KERNEL),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock      (clock),
      .advance    (s1_adv),
      .column     (column),
      .row_ok     (s1_row_ok_ff),
      .col_ok     (s1_col_ok_ff),
      .mode       (lat_mode_ff),
      .fill_value (lat_fill_ff),
      .tap_map    (lat_map_ff),
      .ctr_row    (lat_dr_ff),
      .ctr_col    (lat_dc_ff),
      .result     (win_result)
   );

   // -------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_fire_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_fire_ff) begin
         rsp_pixel_ff <= win_result;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_pixel  = rsp_pixel_ff;
   assign rsp_ch.frame_last = rsp_last_ff;

endmodule

// ===== test/binary_mask_morphology_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_mask_morphology_tb
// Sends raster frames of pixels under many register settings, predicts each
// dilated or eroded result pixel in the testbench and checks every result in
// order, with random idle gaps on the pixel side and stalls on the result
// side.
// ----------------------------------------------------------------------------
module binary_mask_morphology_tb;
   import mbm_pkg::*;

   localparam int CSR_W      = csr_width(MAX_KERNEL_DEF);
   localparam int CYCLE_MAX  = 600000;
   localparam int ITEM_COUNT = 1700;

   typedef struct {
      logic [15:0] pixel;
      logic        last;
   } morph_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   mbm_req_if req_if ();
   mbm_rsp_if rsp_if ();

   binary_mask_morphology u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if.sink),
      .rsp_ch      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // register copies and the values latched at frame start
   logic        cfg_mode;
   logic [15:0] cfg_fill;
   logic [2:0]  cfg_krows, cfg_kcols;
   logic [48:0] cfg_mask;
   logic [10:0] cfg_irows, cfg_icols;
   logic        fr_mode;
   logic [15:0] fr_fill;
   logic [48:0] fr_mask;
   int unsigned fr_kr, fr_kc, fr_rows, fr_cols;

   logic [15:0] line_mem [0:7][0:1023];
   int unsigned in_row, in_col, out_row, out_col;

   morph_result_type pending_results[$];
   int unsigned errors = 0, pixels_sent = 0, results_seen = 0, frames_seen = 0;
   int unsigned stall_left = 0;
   bit          no_gaps = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      req_if.valid    = 1'b0;
      req_if.in_pixel = '0;
      req_if.filler   = 1'b0;
      rsp_if.ready    = 1'b0;
   end

   initial begin
      repeat (CYCLE_MAX) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic int unsigned drain_count(int unsigned kr, int unsigned kc,
                                               int unsigned cols);
      return (kr - 1 - kr / 2) * cols + (kc - 1 - kc / 2);
   endfunction

   function automatic logic [15:0] window_pixel(int unsigned orow, int unsigned ocol);
      int cr, cc, sr, sc;
      bit hit, in_frame;
      logic [15:0] v;
      cr  = fr_kr / 2;
      cc  = fr_kc / 2;
      hit = 0;
      for (int i = 0; i < fr_kr; i++) begin
         for (int j = 0; j < fr_kc; j++) begin
            if (fr_mask[i * MAX_KERNEL_DEF + j]) begin
               sr = int'(orow) + i - cr;
               sc = int'(ocol) + j - cc;
               in_frame = sr >= 0 && sr < int'(fr_rows) && sc >= 0 && sc < int'(fr_cols);
               v = in_frame ? line_mem[sr % 8][sc % 1024] : 16'd0;
               if (fr_mode == MODE_DILATE) begin
                  if (in_frame && v != 0) hit = 1;
               end else begin
                  if (!in_frame || v == 0) hit = 1;
               end
            end
         end
      end
      return hit ? fr_fill : line_mem[orow % 8][ocol % 1024];
   endfunction

   // advance the morphology model by one accepted item
   function automatic void predict_item(logic [15:0] pix, logic fil);
      int unsigned lin, total, lag, o;
      morph_result_type r;
      lin = in_row * fr_cols + in_col;
      if (lin == 0) begin
         if (fil) return;
         fr_mode = cfg_mode;
         fr_fill = cfg_fill;
         fr_kr   = clamp_dim(cfg_krows, MAX_KERNEL_DEF);
         fr_kc   = clamp_dim(cfg_kcols, MAX_KERNEL_DEF);
         fr_mask = cfg_mask;
         fr_rows = clamp_dim(cfg_irows, MAX_ROWS_DEF);
         fr_cols = clamp_dim(cfg_icols, MAX_COLS_DEF);
      end
      total = fr_rows * fr_cols;
      if (lin < total) begin
         if (fil) return;
         line_mem[in_row % 8][in_col % 1024] = pix;
      end
      in_col++;
      if (in_col >= fr_cols) begin
         in_col = 0;
         in_row++;
      end
      lin = in_row * fr_cols + in_col;
      lag = drain_count(fr_kr, fr_kc, fr_cols);
      o   = out_row * fr_cols + out_col;
      if (o + lag >= lin) return;
      r.pixel = window_pixel(out_row, out_col);
      r.last  = (o + 1 >= total);
      pending_results.push_back(r);
      if (r.last) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= fr_cols) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: check each accepted item, then choose the next ready
   always @(posedge clock) begin
      morph_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (rsp_if.frame_last) frames_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result pixel %h last %b", rsp_if.out_pixel,
                        rsp_if.frame_last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.out_pixel !== want.pixel || rsp_if.frame_last !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("result mismatch: expected %h last %b, got %h last %b",
                           want.pixel, want.last, rsp_if.out_pixel, rsp_if.frame_last);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_if.ready <= 1'b1;
      end else begin
         stall_left = gap_len();
         rsp_if.ready <= (stall_left == 0);
      end
   end

   task automatic send_item(input logic [15:0] pix, input logic fil);
      int unsigned n;
      n = gap_len();
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.in_pixel <= pix;
      req_if.filler   <= fil;
      do @(posedge clock); while (!req_if.ready);
      predict_item(pix, fil);
      if (!fil) pixels_sent++;
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic wait_idle();
      hold_until_drained();
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic set_config(input logic md, input logic [15:0] fill,
                             input logic [2:0] kr, input logic [2:0] kc,
                             input logic [48:0] mask,
                             input logic [10:0] rows, input logic [10:0] cols);
      wait_idle();
      csr_write(REG_MODE, CSR_W'(md));
      csr_write(REG_FILL_VALUE, CSR_W'(fill));
      csr_write(REG_KERNEL_ROWS, CSR_W'(kr));
      csr_write(REG_KERNEL_COLS, CSR_W'(kc));
      csr_write(REG_KERNEL_MASK, CSR_W'(mask));
      csr_write(REG_IMAGE_ROWS, CSR_W'(rows));
      csr_write(REG_IMAGE_COLS, CSR_W'(cols));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cfg_mode = md; cfg_fill = fill; cfg_krows = kr; cfg_kcols = kc;
      cfg_mask = mask; cfg_irows = rows; cfg_icols = cols;
   endtask

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // one frame plus the drain items; stray fillers ahead and inside are dropped
   task automatic run_frame(input bit noisy, input bit pressure);
      int unsigned rows, cols, lag;
      rows = clamp_dim(cfg_irows, MAX_ROWS_DEF);
      cols = clamp_dim(cfg_icols, MAX_COLS_DEF);
      lag  = drain_count(clamp_dim(cfg_krows, MAX_KERNEL_DEF),
                         clamp_dim(cfg_kcols, MAX_KERNEL_DEF), cols);
      if (noisy) send_item(rand_pixel(), 1'b1);
      for (int unsigned k = 0; k < rows * cols; k++) begin
         if (noisy && k > 0 && $urandom_range(0, 9) == 0)
            send_item(rand_pixel(), 1'b1);
         if (pressure && $urandom_range(0, 39) == 0) hold_until_drained();
         send_item(rand_pixel(), 1'b0);
      end
      // a plain pixel after the frame's input also drains
      for (int unsigned k = 0; k < lag; k++)
         send_item(rand_pixel(), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed();
      // mask zero passes pixels through
      set_config(MODE_DILATE, 16'h0001, 3'd3, 3'd3, 49'h0, 11'd2, 11'd3);
      run_frame(1, 0);
      set_config(MODE_DILATE, 16'hffff, 3'd3, 3'd3, 49'h1c0e07, 11'd3, 11'd3);
      run_frame(0, 0);
      set_config(MODE_ERODE, 16'h0000, 3'd3, 3'd3, 49'h1c0e07, 11'd3, 11'd4);
      run_frame(1, 0);
      // zero kernel size acts as one tap
      set_config(MODE_ERODE, 16'h5a5a, 3'd0, 3'd0, 49'h1, 11'd1, 11'd1);
      run_frame(0, 0);
      set_config(MODE_DILATE, 16'h1234, 3'd7, 3'd7, {49{1'b1}}, 11'd1, 11'd2);
      run_frame(0, 0);
      set_config(MODE_ERODE, 16'hffff, 3'd7, 3'd1, {49{1'b1}}, 11'd2, 11'd1);
      run_frame(1, 0);
   endtask

   task automatic test_large_frames();
      // an oversized width saturates at the full line length
      set_config(MODE_DILATE, 16'h8001, 3'd3, 3'd5, 49'($urandom), 11'd1, 11'd2047);
      run_frame(0, 1);
   endtask

   task automatic test_random_frames();
      logic [48:0] mask;
      while (pixels_sent < ITEM_COUNT) begin
         mask = {$urandom, $urandom};
         case ($urandom_range(0, 3))
            0: mask = mask & {$urandom, $urandom} & {$urandom, $urandom};
            1: mask = ~mask;
            default: ;
         endcase
         set_config(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom),
                    3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), mask,
                    11'($urandom_range(0, 7)), 11'($urandom_range(0, 14)));
         no_gaps = ($urandom_range(0, 4) == 0);
         run_frame($urandom_range(0, 2) == 0, 1);
      end
      no_gaps = 0;
   endtask

   initial begin
      cfg_mode = MODE_DILATE; cfg_fill = 16'h0001; cfg_krows = 3'd3; cfg_kcols = 3'd3;
      cfg_mask = '0; cfg_irows = 11'd1024; cfg_icols = 11'd1024;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_large_frames();
      test_random_frames();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d pixels, %0d results in %0d frames", pixels_sent,
               results_seen, frames_seen);
      $display("dilate and erode, kernels 1x1 to 7x7, frames up to 1024 pixels wide");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mbm_pkg.sv
design/mbm_stream_if.sv
design/mbm_line_buf.sv
design/mbm_window.sv
design/binary_mask_morphology.sv
test/binary_mask_morphology_tb.sv
